// ===== hdl/ra_pkg.sv =====
// Shared types and constants for the rank assignment block.
`default_nettype none
package ra_pkg;

   // Default capacity of the cell chain
   localparam int MAX_ITEMS_DEF = 64;
   localparam int VALUE_W       = 32;
   localparam int RANK_W        = 6;

   // Input transaction payload
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              overflow;
      logic              end_of_run;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/ra_cell.sv =====
// One cell of the rank chain: holds a value and its rank, forwards the traveling token.
`default_nettype none
module ra_cell #(
   parameter int IDX    = 0,
   parameter int RANK_W = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // token from the previous cell
   input  wire logic                             tok_valid_i,
   input  wire logic signed [ra_pkg::VALUE_W-1:0] tok_value_i,
   input  wire logic [RANK_W-1:0]                tok_carry_i,
   input  wire logic [RANK_W-1:0]                tok_target_i,
   // token to the next cell
   output      logic                             tok_valid_o,
   output      logic signed [ra_pkg::VALUE_W-1:0] tok_value_o,
   output      logic [RANK_W-1:0]                tok_carry_o,
   output      logic [RANK_W-1:0]                tok_target_o,
   // readout shift toward cell zero
   input  wire logic                             shift_i,
   input  wire logic [RANK_W-1:0]                rank_next_i,
   output      logic [RANK_W-1:0]                rank_o
);

   logic signed [ra_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [RANK_W-1:0]                 rank_ff, rank_in;
   logic                              tok_valid_ff, tok_valid_in;
   logic signed [ra_pkg::VALUE_W-1:0] tok_value_ff;
   logic [RANK_W-1:0]                 tok_carry_ff, tok_carry_in;
   logic [RANK_W-1:0]                 tok_target_ff;
   logic                              land;
   logic                              not_greater;

   // Land the token here when this is its slot; otherwise compare and pass it on
   always_comb begin
      land         = tok_valid_i && (tok_target_i == RANK_W'(IDX));
      not_greater  = (value_ff <= tok_value_i);
      value_in     = value_ff;
      rank_in      = rank_ff;
      tok_valid_in = tok_valid_i && !land;
      tok_carry_in = tok_carry_i;
      if (land) begin
         value_in = tok_value_i;
         rank_in  = tok_carry_i;
      end else if (tok_valid_i) begin
         if (not_greater) begin
            tok_carry_in = tok_carry_i + RANK_W'(1);
         end else begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end else if (shift_i) begin
         rank_in = rank_next_i;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      rank_ff       <= rank_in;
      tok_value_ff  <= tok_value_i;
      tok_carry_ff  <= tok_carry_in;
      tok_target_ff <= tok_target_i;
   end

   // Advance token valid
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   assign tok_valid_o  = tok_valid_ff;
   assign tok_value_o  = tok_value_ff;
   assign tok_carry_o  = tok_carry_ff;
   assign tok_target_o = tok_target_ff;
   assign rank_o       = rank_ff;

endmodule
`default_nettype wire

// ===== hdl/rank_assign.sv =====
// Top level of the rank assignment block: controller and chain of rank cells.
// Throughput: one input transaction per cycle while a run is collected.
// After the last transaction the controller counts down in ST_DRAIN from the slot of the
// last stored value (at most MAX_ITEMS-1) while the token walks the chain; then one result
// per cycle from cell zero while rsp_ready is high; input stalls until the last is taken.
// Reset clears the control state only; no clearing pass is needed.
`default_nettype none
module rank_assign #(
   parameter int MAX_ITEMS = ra_pkg::MAX_ITEMS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire ra_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      ra_pkg::rsp_type rsp_data
);

   localparam int RW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   ra_pkg::state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [RW-1:0]     drain_ff, drain_in;
   logic [CW-1:0]     remain_ff, remain_in;
   logic              accept;
   logic              pop;
   logic              full;
   logic              shift;
   logic [RW+ra_pkg::RANK_W-1:0] rank_wide;

   // Token and rank links of the chain
   logic [MAX_ITEMS:0]                tok_valid;
   logic signed [ra_pkg::VALUE_W-1:0] tok_value  [MAX_ITEMS+1];
   logic [RW-1:0]                     tok_carry  [MAX_ITEMS+1];
   logic [RW-1:0]                     tok_target [MAX_ITEMS+1];
   logic [RW-1:0]                     rank       [MAX_ITEMS+1];

   assign req_ready = (state_ff == ra_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == ra_pkg::ST_EMIT);
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign shift     = pop;
   assign full      = (count_ff == CW'(MAX_ITEMS));

   // Inject a new token at the head of the chain
   assign tok_valid[0]  = accept && !full;
   assign tok_value[0]  = req_data.value;
   assign tok_carry[0]  = '0;
   assign tok_target[0] = count_ff[RW-1:0];
   assign rank[MAX_ITEMS] = '0;

   // Next state and counters
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      drain_in   = drain_ff;
      remain_in  = remain_ff;
      unique case (state_ff)
         ra_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last) begin
                  state_in = ra_pkg::ST_DRAIN;
                  if (full) begin
                     drain_in  = RW'(MAX_ITEMS - 1);
                     remain_in = count_ff;
                  end else begin
                     drain_in  = count_ff[RW-1:0];
                     remain_in = count_ff + CW'(1);
                  end
               end
            end
         end
         ra_pkg::ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ra_pkg::ST_EMIT;
            end else begin
               drain_in = drain_ff - RW'(1);
            end
         end
         ra_pkg::ST_EMIT: begin
            if (pop) begin
               remain_in = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in   = ra_pkg::ST_LOAD;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ra_pkg::ST_LOAD;
         end
      endcase
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ra_pkg::ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         drain_ff   <= '0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         drain_ff   <= drain_in;
         remain_ff  <= remain_in;
      end
   end

   // Build the chain of cells
   for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
      ra_cell #(
         .IDX    (j),
         .RANK_W (RW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .tok_valid_i  (tok_valid[j]),
         .tok_value_i  (tok_value[j]),
         .tok_carry_i  (tok_carry[j]),
         .tok_target_i (tok_target[j]),
         .tok_valid_o  (tok_valid[j+1]),
         .tok_value_o  (tok_value[j+1]),
         .tok_carry_o  (tok_carry[j+1]),
         .tok_target_o (tok_target[j+1]),
         .shift_i      (shift),
         .rank_next_i  (rank[j+1]),
         .rank_o       (rank[j])
      );
   end

   // Present cell zero as the result; rank is reported modulo 64
   assign rank_wide           = {{ra_pkg::RANK_W{1'b0}}, rank[0]};
   assign rsp_data.rank       = rank_wide[ra_pkg::RANK_W-1:0];
   assign rsp_data.overflow   = dropped_ff;
   assign rsp_data.end_of_run = (remain_ff == CW'(1));

endmodule
`default_nettype wire

// ===== hdl/ra_checker.sv =====
// Port-level checker for the rank assignment block, bound to the top level.
`default_nettype none
module ra_checker (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire ra_pkg::req_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire ra_pkg::rsp_type rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while results pending");

   // Closing a run stalls input
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("input still ready after last transaction");

   // Final result reopens input
   a_end_reopens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.end_of_run |=> req_ready && !rsp_valid)
      else $error("input not reopened after end of run");

   // Overflow is constant over a run
   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.end_of_run |=>
         rsp_valid && (rsp_data.overflow == $past(rsp_data.overflow)))
      else $error("overflow changed within a run");

endmodule

bind rank_assign ra_checker u_ra_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
